FILE: design/ssf_pkg.sv
package ssf_pkg;

  localparam int DT_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_FIN,
    ST_SETTLE
  } state_t;

  typedef enum logic [1:0] {
    OP_RATE,
    OP_TARGET,
    OP_DELTA,
    OP_EASE
  } op_t;

  typedef enum logic [2:0] {
    REG_TARGET_ALPHA    = 3'd0,
    REG_EASE_ALPHA_AWAY = 3'd1,
    REG_EASE_ALPHA_BACK = 3'd2,
    REG_ON_RATE_UP      = 3'd3,
    REG_OFF_RATE_UP     = 3'd4,
    REG_ON_RATE_DOWN    = 3'd5,
    REG_OFF_RATE_DOWN   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul;
    logic fin;
    logic settle;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic jump;
  } dp_status_t;

endpackage

FILE: design/ssf_regs.sv
module ssf_regs import ssf_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int ALPHA_BITS = 16,
  localparam int DATA_W = (VALUE_WIDTH - 1 > 32) ? 64 : 32,
  localparam int STRIDE_LOG = (DATA_W == 64) ? 3 : 2,
  localparam int ADDR_W = STRIDE_LOG + 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output logic [ALPHA_BITS:0]    target_alpha,
  output logic [ALPHA_BITS:0]    ease_alpha_away,
  output logic [ALPHA_BITS:0]    ease_alpha_back,
  output logic [VALUE_WIDTH-2:0] on_rate_up,
  output logic [VALUE_WIDTH-2:0] off_rate_up,
  output logic [VALUE_WIDTH-2:0] on_rate_down,
  output logic [VALUE_WIDTH-2:0] off_rate_down
);

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:STRIDE_LOG]);
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_alpha    <= '0;
      ease_alpha_away <= '0;
      ease_alpha_back <= '0;
      on_rate_up      <= '0;
      off_rate_up     <= '0;
      on_rate_down    <= '0;
      off_rate_down   <= '0;
    end else if (wr) begin
      case (idx)
        REG_TARGET_ALPHA:    target_alpha    <= pwdata[ALPHA_BITS:0];
        REG_EASE_ALPHA_AWAY: ease_alpha_away <= pwdata[ALPHA_BITS:0];
        REG_EASE_ALPHA_BACK: ease_alpha_back <= pwdata[ALPHA_BITS:0];
        REG_ON_RATE_UP:      on_rate_up      <= pwdata[VALUE_WIDTH-2:0];
        REG_OFF_RATE_UP:     off_rate_up     <= pwdata[VALUE_WIDTH-2:0];
        REG_ON_RATE_DOWN:    on_rate_down    <= pwdata[VALUE_WIDTH-2:0];
        REG_OFF_RATE_DOWN:   off_rate_down   <= pwdata[VALUE_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_ALPHA:    prdata = DATA_W'(target_alpha);
      REG_EASE_ALPHA_AWAY: prdata = DATA_W'(ease_alpha_away);
      REG_EASE_ALPHA_BACK: prdata = DATA_W'(ease_alpha_back);
      REG_ON_RATE_UP:      prdata = DATA_W'(on_rate_up);
      REG_OFF_RATE_UP:     prdata = DATA_W'(off_rate_up);
      REG_ON_RATE_DOWN:    prdata = DATA_W'(on_rate_down);
      REG_OFF_RATE_DOWN:   prdata = DATA_W'(off_rate_down);
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: design/ssf_ctrl.sv
module ssf_ctrl import ssf_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       command,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int NCH = (VALUE_WIDTH + 31) / 32;
  localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_RATE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_next     = OP_RATE;
          state_next  = command ? ST_SETTLE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        cnt_next = '0;
        if (op == OP_EASE && status.jump) begin
          state_next = ST_SETTLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (cnt == CNT_W'(NCH - 1)) begin
          state_next = ST_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        if (op == OP_EASE) begin
          state_next = ST_SETTLE;
        end else begin
          op_next    = op_t'(2'(op) + 2'd1);
          state_next = ST_LOAD;
        end
      end
      ST_SETTLE: begin
        if (!out_valid || out_ready) begin
          cmd.settle = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.settle | (out_valid & ~out_ready);
  end

endmodule

FILE: design/ssf_datapath.sv
module ssf_datapath import ssf_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int ALPHA_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  input  logic                          command,
  input  logic signed [VALUE_WIDTH-1:0] target_value,
  input  logic [DT_BITS-1:0]            time_step,
  input  logic                          forward_dir,
  input  logic [ALPHA_BITS:0]           target_alpha,
  input  logic [ALPHA_BITS:0]           ease_alpha_away,
  input  logic [ALPHA_BITS:0]           ease_alpha_back,
  input  logic [VALUE_WIDTH-2:0]        on_rate_up,
  input  logic [VALUE_WIDTH-2:0]        off_rate_up,
  input  logic [VALUE_WIDTH-2:0]        on_rate_down,
  input  logic [VALUE_WIDTH-2:0]        off_rate_down,
  output logic signed [VALUE_WIDTH-1:0] smoothed_value
);

  localparam int W   = VALUE_WIDTH;
  localparam int NCH = (W + 31) / 32;
  localparam int CH  = (W + NCH - 1) / NCH;
  localparam int MW  = NCH * CH;
  localparam int CW  = (ALPHA_BITS + 1 > DT_BITS) ? ALPHA_BITS + 1 : DT_BITS;
  localparam int PW  = MW + CW + 1;
  localparam int RW  = W + 3;
  localparam int SW  = W + 4;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
    logic fits;
    fits = (x[SW-1:W-1] == '0) || (x[SW-1:W-1] == '1);
    if (fits) begin
      return x[W-1:0];
    end else if (x[SW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] x);
    return x[W-1] ? W'(-x) : W'(x);
  endfunction

  logic                 cmd_q, fwd_q;
  logic signed [W-1:0]  tgt_q, pft, step, val, delta;
  logic [DT_BITS-1:0]   dt_q;
  logic [W-1:0]         lim;
  logic [MW-1:0]        mag_op;
  logic [CW-1:0]        coef_op;
  logic                 neg_op;
  logic [PW-1:0]        acc;

  logic                 val_neg, val_pos, tgt_neg, tgt_pos, is_up, opp, val_beyond;
  logic [W-2:0]         on_r, off_r, rate_sel;
  logic signed [W-1:0]  opa, opb;
  logic signed [W:0]    diff;
  logic [W:0]           diff_abs;
  logic [W-1:0]         delta_abs, step_abs;
  logic                 use_away;
  logic [MW-1:0]        mag_sel;
  logic [CW-1:0]        coef_sel;
  logic                 neg_sel;
  logic [CH-1:0]        chunk;
  logic [CH+CW-1:0]     prod;
  logic [PW-1:0]        rnd_a, rnd_t;
  logic [W+1:0]         r_mag;
  logic signed [RW-1:0] r_val;
  logic signed [SW-1:0] base, sum;
  logic signed [W-1:0]  sum_sat;
  logic [W-1:0]         mv;
  logic signed [SW-1:0] mv_s, moved;
  logic signed [W-1:0]  val_new;

  always_comb begin
    val_neg    = val[W-1];
    val_pos    = !val_neg && (val != '0);
    tgt_neg    = tgt_q[W-1];
    tgt_pos    = !tgt_neg && (tgt_q != '0);
    is_up      = (!val_neg) == fwd_q;
    on_r       = is_up ? on_rate_up : on_rate_down;
    off_r      = is_up ? off_rate_up : off_rate_down;
    opp        = (val_neg && tgt_pos) || (val_pos && tgt_neg);
    val_beyond = abs_w(val) > abs_w(tgt_q);
    if (opp) begin
      rate_sel = (on_r > off_r) ? on_r : off_r;
    end else if (val_beyond) begin
      rate_sel = off_r;
    end else begin
      rate_sel = on_r;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_TARGET: begin
        opa = tgt_q;
        opb = pft;
      end
      OP_DELTA: begin
        opa = pft;
        opb = val;
      end
      default: begin
        opa = delta;
        opb = step;
      end
    endcase
    diff        = $signed({opa[W-1], opa}) - $signed({opb[W-1], opb});
    diff_abs    = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
    delta_abs   = abs_w(delta);
    step_abs    = abs_w(step);
    status.jump = !((delta_abs > step_abs) || (delta[W-1] != step[W-1]));
    use_away    = (val[W-1] == delta[W-1]);
    case (cmd.op)
      OP_RATE: begin
        mag_sel  = MW'(rate_sel);
        coef_sel = CW'(dt_q);
        neg_sel  = 1'b0;
      end
      OP_TARGET, OP_DELTA: begin
        mag_sel  = MW'(diff_abs[W-1:0]);
        coef_sel = CW'(target_alpha);
        neg_sel  = diff[W];
      end
      default: begin
        mag_sel  = MW'(diff_abs[W-1:0]);
        coef_sel = use_away ? CW'(ease_alpha_away) : CW'(ease_alpha_back);
        neg_sel  = diff[W];
      end
    endcase
  end

  assign chunk = mag_op[MW-1 -: CH];
  assign prod  = (CH+CW)'(chunk) * (CH+CW)'(coef_op);

  always_comb begin
    rnd_a = acc + (PW'(1) << (ALPHA_BITS - 1));
    rnd_t = acc + (PW'(1) << (DT_BITS - 1));
    r_mag = rnd_a[ALPHA_BITS +: W+2];
    r_val = neg_op ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    case (cmd.op)
      OP_TARGET: base = SW'(pft);
      OP_EASE:   base = SW'(step);
      default:   base = '0;
    endcase
    sum     = base + SW'(r_val);
    sum_sat = sat_w(sum);
  end

  always_comb begin
    mv      = (step_abs > lim) ? lim : step_abs;
    mv_s    = $signed(SW'(mv));
    moved   = SW'(val) + (step[W-1] ? -mv_s : mv_s);
    val_new = cmd_q ? tgt_q : sat_w(moved);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pft  <= '0;
      step <= '0;
      val  <= '0;
    end else begin
      if (cmd.fin && cmd.op == OP_TARGET) begin
        pft <= sum_sat;
      end else if (cmd.settle && cmd_q) begin
        pft <= '0;
      end
      if (cmd.load && cmd.op == OP_EASE && status.jump) begin
        step <= delta;
      end else if (cmd.fin && cmd.op == OP_EASE) begin
        step <= sum_sat;
      end else if (cmd.settle && cmd_q) begin
        step <= '0;
      end
      if (cmd.settle) begin
        val <= val_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= command;
      tgt_q <= target_value;
      dt_q  <= time_step;
      fwd_q <= forward_dir;
    end
    if (cmd.load) begin
      mag_op  <= mag_sel;
      coef_op <= coef_sel;
      neg_op  <= neg_sel;
      acc     <= '0;
    end else if (cmd.mul) begin
      acc    <= (acc << CH) + PW'(prod);
      mag_op <= mag_op << CH;
    end
    if (cmd.fin && cmd.op == OP_RATE) begin
      lim <= rnd_t[DT_BITS +: W];
    end
    if (cmd.fin && cmd.op == OP_DELTA) begin
      delta <= sum_sat;
    end
    if (cmd.settle) begin
      smoothed_value <= val_new;
    end
  end

endmodule

FILE: design/smoothed_setpoint_slew_filter_core.sv
// Smoothed setpoint slew filter in signed fixed point. Each update transaction runs an EMA of
// the target, scales the gap from the current value to that EMA by the target alpha to form
// a delta, eases a step toward that delta, and moves the setpoint by the step clipped to a
// direction- and overshoot-dependent speed limit times time_step; a reset transaction loads
// the setpoint and clears both filters. Coefficients and rate limits come from APB registers.
// One shared multiplier does four products per update (rate limit, target EMA, delta, step
// easing), each a load step, one multiply step per magnitude chunk, NCH = ceil(VALUE_WIDTH/32)
// chunks in all, and a finish step; the easing product stops after its load when the step
// snaps to the delta. A settle step then presents the result; a reset goes to it straight
// from acceptance. The next transaction can be taken in the same cycle that a result is
// presented. One transaction is in flight at a time, and the result register lets the next
// one be taken while a finished result waits.
module smoothed_setpoint_slew_filter_core import ssf_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int ALPHA_BITS = 16,
  localparam int DATA_W = (VALUE_WIDTH - 1 > 32) ? 64 : 32,
  localparam int ADDR_W = (DATA_W == 64) ? 6 : 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic signed [VALUE_WIDTH-1:0] target_value,
  input  logic [DT_BITS-1:0]            time_step,
  input  logic                          forward_dir,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] smoothed_value
);

  logic [ALPHA_BITS:0]    target_alpha, ease_alpha_away, ease_alpha_back;
  logic [VALUE_WIDTH-2:0] on_rate_up, off_rate_up, on_rate_down, off_rate_down;
  dp_cmd_t                cmd;
  dp_status_t             status;

  ssf_regs #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .ALPHA_BITS (ALPHA_BITS)
  ) u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .target_alpha   (target_alpha),
    .ease_alpha_away(ease_alpha_away),
    .ease_alpha_back(ease_alpha_back),
    .on_rate_up     (on_rate_up),
    .off_rate_up    (off_rate_up),
    .on_rate_down   (on_rate_down),
    .off_rate_down  (off_rate_down)
  );

  ssf_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .status   (status),
    .cmd      (cmd)
  );

  ssf_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .ALPHA_BITS (ALPHA_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .command        (command),
    .target_value   (target_value),
    .time_step      (time_step),
    .forward_dir    (forward_dir),
    .target_alpha   (target_alpha),
    .ease_alpha_away(ease_alpha_away),
    .ease_alpha_back(ease_alpha_back),
    .on_rate_up     (on_rate_up),
    .off_rate_up    (off_rate_up),
    .on_rate_down   (on_rate_down),
    .off_rate_down  (off_rate_down),
    .smoothed_value (smoothed_value)
  );

endmodule

FILE: design/ssf_checker.sv
module ssf_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          command,
  input logic signed [VALUE_WIDTH-1:0] target_value,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [VALUE_WIDTH-1:0] smoothed_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smoothed_value))
    else $error("result changed or dropped while stalled");

  a_reset_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command && (!out_valid || out_ready)
    |-> ##2 (out_valid && smoothed_value == $past(target_value, 2)))
    else $error("reset transaction did not return the loaded value");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in progress");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input side went busy without a transaction");

endmodule

bind smoothed_setpoint_slew_filter_core ssf_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_ssf_checker (.*);

FILE: tb/smoothed_setpoint_slew_filter_core_test.sv
`timescale 1ns / 1ps

module smoothed_setpoint_slew_filter_core_test;
  import ssf_pkg::*;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_RESET = 1'b1;
  localparam logic FWD = 1'b1;
  localparam logic REV = 1'b0;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [30:0] RATE_MAX = 31'h7FFFFFFF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic command;
  logic signed [31:0] target_value;
  logic [DT_BITS-1:0] time_step;
  logic forward_dir;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] smoothed_value;

  smoothed_setpoint_slew_filter_core u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .target_value(target_value),
    .time_step(time_step),
    .forward_dir(forward_dir),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .smoothed_value(smoothed_value)
  );

  logic [16:0] alpha_target;
  logic [16:0] alpha_away;
  logic [16:0] alpha_back;
  logic [30:0] rate_on_up;
  logic [30:0] rate_off_up;
  logic [30:0] rate_on_down;
  logic [30:0] rate_off_down;

  longint filt_target;
  longint ease_step;
  longint setpoint;

  logic signed [31:0] pending_setpoints[$];
  logic signed [31:0] want_setpoint;
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int results_seen;
  int items_sent;
  int settings_applied;
  int idle_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint clamp_value(longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  // round to nearest on the magnitude, ties away from zero
  function automatic longint scale_q16(longint x, longint coef);
    longint prod;
    prod = magnitude(x) * coef;
    prod = (prod >> 16) + prod[15];
    return (x < 0) ? -prod : prod;
  endfunction

  function automatic logic signed [31:0] next_setpoint(logic cmd, logic signed [31:0] tgt_in,
                                                       logic [DT_BITS-1:0] dt, logic fwd);
    longint tgt, cur, delta, on_r, off_r, rate, lim, mag;
    logic moving_up;
    tgt = tgt_in;
    if (cmd == CMD_RESET) begin
      filt_target = 0;
      ease_step = 0;
      setpoint = tgt;
    end else begin
      cur = setpoint;
      moving_up = ((cur >= 0) == fwd);
      filt_target = clamp_value(filt_target + scale_q16(tgt - filt_target, alpha_target));
      delta = clamp_value(scale_q16(filt_target - cur, alpha_target));
      if (magnitude(delta) > magnitude(ease_step) || ((delta < 0) != (ease_step < 0))) begin
        ease_step = clamp_value(ease_step + scale_q16(delta - ease_step,
                                ((cur < 0) == (delta < 0)) ? alpha_away : alpha_back));
      end else begin
        ease_step = delta;
      end
      on_r = moving_up ? rate_on_up : rate_on_down;
      off_r = moving_up ? rate_off_up : rate_off_down;
      if ((cur < 0 && tgt > 0) || (cur > 0 && tgt < 0)) begin
        rate = (on_r > off_r) ? on_r : off_r;
      end else if (magnitude(cur) > magnitude(tgt)) begin
        rate = off_r;
      end else begin
        rate = on_r;
      end
      lim = rate * longint'(dt);
      lim = (lim >> DT_BITS) + lim[DT_BITS-1];
      mag = magnitude(ease_step);
      if (mag > lim) mag = lim;
      setpoint = clamp_value(cur + ((ease_step < 0) ? -mag : mag));
    end
    return setpoint[31:0];
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_setpoints.size() == 0) begin
        $error("smoothed_value: expected none, actual %0d", smoothed_value);
        mismatches++;
      end else begin
        want_setpoint = pending_setpoints.pop_front();
        results_seen++;
        if (smoothed_value !== want_setpoint) begin
          $error("smoothed_value: expected %0d, actual %0d", want_setpoint, smoothed_value);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic cmd, logic signed [31:0] tgt, logic [DT_BITS-1:0] dt,
                           logic fwd);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    target_value <= tgt;
    time_step <= dt;
    forward_dir <= fwd;
    do @(posedge clk); while (!in_ready);
    pending_setpoints.push_back(next_setpoint(cmd, tgt, dt, fwd));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TARGET_ALPHA: alpha_target = value[16:0];
      REG_EASE_ALPHA_AWAY: alpha_away = value[16:0];
      REG_EASE_ALPHA_BACK: alpha_back = value[16:0];
      REG_ON_RATE_UP: rate_on_up = value[30:0];
      REG_OFF_RATE_UP: rate_off_up = value[30:0];
      REG_ON_RATE_DOWN: rate_on_down = value[30:0];
      REG_OFF_RATE_DOWN: rate_off_down = value[30:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_settings(logic [16:0] ta, logic [16:0] aw, logic [16:0] bk,
                                logic [30:0] onu, logic [30:0] offu, logic [30:0] ond,
                                logic [30:0] offd);
    write_reg(REG_TARGET_ALPHA, 32'(ta));
    write_reg(REG_EASE_ALPHA_AWAY, 32'(aw));
    write_reg(REG_EASE_ALPHA_BACK, 32'(bk));
    write_reg(REG_ON_RATE_UP, 32'(onu));
    write_reg(REG_OFF_RATE_UP, 32'(offu));
    write_reg(REG_ON_RATE_DOWN, 32'(ond));
    write_reg(REG_OFF_RATE_DOWN, 32'(offd));
    settings_applied++;
  endtask

  function automatic logic [30:0] random_rate();
    case ($urandom_range(2))
      0: return 31'($urandom_range(32'h7FFFFFFF));
      1: return 31'($urandom_range(32'h400000));
      default: return 31'($urandom_range(32'h4000000));
    endcase
  endfunction

  task automatic send_random_item();
    logic signed [31:0] tgt;
    logic [DT_BITS-1:0] dt;
    case ($urandom_range(3))
      0: tgt = $urandom;
      1: tgt = setpoint[31:0] + 32'($urandom_range(32'h200000)) - 32'h100000;
      2: tgt = 32'($urandom_range(32'h200000)) - 32'h100000;
      default: tgt = $urandom;
    endcase
    dt = ($urandom_range(1) == 0) ? DT_BITS'($urandom_range(16'hFFFF))
                                  : DT_BITS'($urandom_range(2000));
    send_item(($urandom_range(99) < 8) ? CMD_RESET : CMD_UPDATE, tgt, dt,
              logic'($urandom_range(1)));
  endtask

  task automatic test_default_registers();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(CMD_UPDATE, 32'h7FFFFFFF, 16'hFFFF, FWD);
    send_item(CMD_RESET, 32'h80000000, 16'hFFFF, FWD);
    send_item(CMD_UPDATE, 32'h00000000, 16'hFFFF, REV);
    send_item(CMD_RESET, 32'h00000000, 16'h0000, REV);
    wait_drained();
  endtask

  task automatic test_directed_cases();
    apply_settings(ALPHA_ONE, ALPHA_ONE, 17'd32768, 31'(100 << 16), 31'(300 << 16),
                   31'(40 << 16), RATE_MAX);
    send_item(CMD_RESET, 32'sd0, 16'h0000, FWD);
    send_item(CMD_UPDATE, 32'sd5 <<< 16, 16'hFFFF, FWD);
    send_item(CMD_UPDATE, 32'sd5 <<< 16, 16'd6553, FWD);
    send_item(CMD_UPDATE, 32'sd1 <<< 16, 16'hFFFF, FWD);
    send_item(CMD_UPDATE, -(32'sd8 <<< 16), 16'hFFFF, REV);
    send_item(CMD_UPDATE, -(32'sd8 <<< 16), 16'h0000, REV);
    send_item(CMD_UPDATE, 32'sd0, 16'hFFFF, FWD);
    send_item(CMD_RESET, 32'h7FFFFFFF, 16'h0000, REV);
    send_item(CMD_UPDATE, 32'h80000000, 16'hFFFF, FWD);
    send_item(CMD_UPDATE, 32'h7FFFFFFF, 16'hFFFF, REV);
    send_item(CMD_RESET, 32'h80000000, 16'hFFFF, FWD);
    send_item(CMD_UPDATE, 32'h80000000, 16'hFFFF, REV);
    send_item(CMD_UPDATE, 32'h7FFFFFFF, 16'hFFFF, FWD);
    wait_drained();
    apply_settings(ALPHA_ONE, ALPHA_ONE, ALPHA_ONE, RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX);
    send_item(CMD_RESET, 32'h80000000, 16'h0000, FWD);
    send_item(CMD_UPDATE, 32'h7FFFFFFF, 16'hFFFF, FWD);
    send_item(CMD_UPDATE, 32'h7FFFFFFF, 16'hFFFF, REV);
    send_item(CMD_UPDATE, 32'h80000000, 16'hFFFF, FWD);
    send_item(CMD_UPDATE, 32'h80000000, 16'h0001, REV);
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        apply_settings(ALPHA_ONE, ALPHA_ONE, ALPHA_ONE, RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX);
      end else if (phase == 1) begin
        apply_settings('0, '0, '0, '0, '0, '0, '0);
      end else begin
        apply_settings(17'($urandom_range(65536)), 17'($urandom_range(65536)),
                       17'($urandom_range(65536)), random_rate(), random_rate(),
                       random_rate(), random_rate());
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      repeat (70) send_random_item();
      wait_drained();
    end
  endtask

  task automatic test_drain_between_bursts();
    send_idle_pct = 23;
    recv_stall_pct = 23;
    apply_settings(17'd20000, 17'd50000, 17'd8000, 31'(500 << 16), 31'(2000 << 16),
                   31'(300 << 16), 31'(1500 << 16));
    repeat (4) begin
      repeat (10) send_random_item();
      wait_drained();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    command = CMD_UPDATE;
    target_value = '0;
    time_step = '0;
    forward_dir = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    settings_applied = 0;
    idle_cycles = 0;
    alpha_target = '0;
    alpha_away = '0;
    alpha_back = '0;
    rate_on_up = '0;
    rate_off_up = '0;
    rate_on_down = '0;
    rate_off_down = '0;
    filt_target = 0;
    ease_step = 0;
    setpoint = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_registers();
    test_directed_cases();
    test_random_phases();
    test_drain_between_bursts();

    $display("Sent %0d transactions (updates and resets) under %0d register settings,",
             items_sent, settings_applied);
    $display("checked %0d results with sender gaps and receiver stalls mixed in.",
             results_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
